### rtl/core/utfx_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the unicode transcoder
// no dependencies; used by the front, queue, back, top level and testbench
package utfx_pkg;

    // encoding codes for the source and target format registers
    localparam logic [1:0] FMT_UTF8  = 2'd0;
    localparam logic [1:0] FMT_UTF16 = 2'd1;
    localparam logic [1:0] FMT_UTF32 = 2'd2;

    // register word indexes on the configuration port
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    localparam int PADDR_W = 3;

    typedef logic [31:0] t_point;

    // decoded code point handed from the front to the queue
    typedef struct packed {
        logic   valid;
        t_point point;
    } t_push;

    // queue occupancy reported by the queue to the top level
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_qstat;

endpackage

### rtl/core/utfx_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for source units and target units
// no dependencies
interface utfx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_unit;
    logic        end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface utfx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_unit;
    logic        last_in_run;

    modport source (output valid, output out_unit, output last_in_run, input ready);
    modport sink   (input valid, input out_unit, input last_in_run, output ready);
endinterface

### rtl/core/utfx_front.sv
`timescale 1ns / 1ps
// front end: accepts source units and decodes them into code points
// depends on utfx_pkg
module utfx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_source_fmt,
    input  logic           i_clear,
    input  logic           i_accept,
    input  logic [31:0]    i_code_unit,
    input  logic           i_end_of_text,
    output utfx_pkg::t_push o_push
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_pending, n_pending;
    logic        r_await,   n_await;
    logic [7:0]  w_byte;
    logic [15:0] w_half;
    logic [20:0] w_acc;

    assign w_byte = i_code_unit[7:0];
    assign w_half = i_code_unit[15:0];

    // continuation byte lands at bit 6*(pending-1)
    always_comb begin
        case (r_pending)
            2'd1:    w_acc = r_partial | {15'b0, w_byte[5:0]};
            2'd2:    w_acc = r_partial | {9'b0, w_byte[5:0], 6'b0};
            default: w_acc = r_partial | {3'b0, w_byte[5:0], 12'b0};
        endcase
    end

    always_comb begin
        n_partial    = r_partial;
        n_pending    = r_pending;
        n_await      = r_await;
        o_push.valid = 1'b0;
        o_push.point = '0;
        if (i_accept) begin
            unique case (i_source_fmt)
                utfx_pkg::FMT_UTF8: begin
                    if (r_pending != 2'd0) begin
                        n_pending = r_pending - 2'd1;
                        if (r_pending == 2'd1) begin
                            o_push.valid = 1'b1;
                            o_push.point = {11'b0, w_acc};
                            n_partial    = '0;
                        end else begin
                            n_partial = w_acc;
                        end
                    end else if (!w_byte[7]) begin
                        o_push.valid = 1'b1;
                        o_push.point = {24'b0, w_byte};
                    end else if (w_byte[7:5] == 3'b110) begin
                        n_partial = {10'b0, w_byte[4:0], 6'b0};
                        n_pending = 2'd1;
                    end else if (w_byte[7:4] == 4'b1110) begin
                        n_partial = {5'b0, w_byte[3:0], 12'b0};
                        n_pending = 2'd2;
                    end else if (w_byte[7:3] == 5'b11110) begin
                        n_partial = {w_byte[2:0], 18'b0};
                        n_pending = 2'd3;
                    end else begin
                        // bad lead byte decodes as zero
                        o_push.valid = 1'b1;
                        o_push.point = '0;
                    end
                end
                utfx_pkg::FMT_UTF16: begin
                    if (r_await) begin
                        // high offset plus low unit minus 0xdc00 plus 0x10000
                        o_push.valid = 1'b1;
                        o_push.point = {11'b0, ({1'b0, r_partial[9:0], 10'b0}
                                       + {5'b0, w_half} + 21'h002400)};
                        n_await      = 1'b0;
                        n_partial    = '0;
                    end else if (w_half[15:10] == 6'b110110) begin
                        n_partial = {11'b0, w_half[9:0]};
                        n_await   = 1'b1;
                    end else begin
                        o_push.valid = 1'b1;
                        o_push.point = {16'b0, w_half};
                    end
                end
                default: begin
                    o_push.valid = 1'b1;
                    o_push.point = i_code_unit;
                end
            endcase
            if (i_end_of_text) begin
                n_partial = '0;
                n_pending = '0;
                n_await   = 1'b0;
            end
        end
        if (i_clear) begin
            n_partial = '0;
            n_pending = '0;
            n_await   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= '0;
            r_await   <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_await   <= n_await;
        end
    end

endmodule

### rtl/core/utfx_queue.sv
`timescale 1ns / 1ps
// two-entry code point queue between the front and back ends
// depends on utfx_pkg
module utfx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  utfx_pkg::t_push  i_push,
    input  logic             i_pop,
    output utfx_pkg::t_point o_head,
    output utfx_pkg::t_qstat o_stat
);

    utfx_pkg::t_point r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.count = r_count;
    assign o_head       = r_mem[r_rp];

    assign w_wr = i_push.valid && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push.point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

### rtl/core/utfx_back.sv
`timescale 1ns / 1ps
// back end: encodes the head into target units, one per unstalled cycle
// depends on utfx_pkg and utfx_out_if
module utfx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_target_fmt,
    input  utfx_pkg::t_point i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    utfx_out_if.source       o_out
);

    logic [3:0][31:0] w_units;
    logic [1:0]       w_last_idx;
    logic [31:0]      w_off;
    logic             w_load;
    logic             w_last;
    logic [1:0]       r_idx;
    logic             r_valid;
    logic [31:0]      r_unit;
    logic             r_last;

    assign w_off = i_head - 32'h0001_0000;

    always_comb begin
        w_units    = '0;
        w_last_idx = 2'd0;
        unique case (i_target_fmt)
            utfx_pkg::FMT_UTF8: begin
                if (i_head[31:7] == '0) begin
                    w_units[0] = i_head;
                end else if (i_head[31:11] == '0) begin
                    w_units[0] = {24'b0, 3'b110, i_head[10:6]};
                    w_units[1] = {24'b0, 2'b10, i_head[5:0]};
                    w_last_idx = 2'd1;
                end else if (i_head[31:16] == '0) begin
                    w_units[0] = {24'b0, 4'b1110, i_head[15:12]};
                    w_units[1] = {24'b0, 2'b10, i_head[11:6]};
                    w_units[2] = {24'b0, 2'b10, i_head[5:0]};
                    w_last_idx = 2'd2;
                end else begin
                    // lead byte keeps whatever lands above bit 20
                    w_units[0] = {24'b0, 8'hF0 | i_head[25:18]};
                    w_units[1] = {24'b0, 2'b10, i_head[17:12]};
                    w_units[2] = {24'b0, 2'b10, i_head[11:6]};
                    w_units[3] = {24'b0, 2'b10, i_head[5:0]};
                    w_last_idx = 2'd3;
                end
            end
            utfx_pkg::FMT_UTF16: begin
                if (i_head[31:16] == '0) begin
                    w_units[0] = i_head;
                end else begin
                    w_units[0] = {16'b0, 16'hD800 | w_off[25:10]};
                    w_units[1] = {16'b0, 6'b110111, w_off[9:0]};
                    w_last_idx = 2'd1;
                end
            end
            default: begin
                w_units[0] = i_head;
            end
        endcase
    end

    assign w_load = !r_valid || o_out.ready;
    assign w_last = (r_idx == w_last_idx);
    assign o_pop  = i_head_valid && w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_head_valid) begin
            r_unit <= w_units[r_idx];
            r_last <= w_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_unit    = r_unit;
    assign o_out.last_in_run = r_last;

endmodule

### rtl/core/unicode_utf_transcoder.sv
`timescale 1ns / 1ps
// Transcodes a stream of UTF-8, UTF-16 or UTF-32 source units into target units of a
// configured encoding without validation. Each accepted source unit is decoded in the
// front end in the cycle it arrives; a completed code point enters a two-entry queue,
// and the back end turns the queue head into one to four target units, one unit per
// cycle into an output register while the output is not stalled, marking the last
// unit of each code point. Input is taken every cycle as long as the queue has room,
// so a stream whose code points each make one target unit moves at one unit per cycle
// while the output is not stalled; a code point that makes more than one target unit
// holds the back end's unit counter until its last unit is loaded, and the front stalls
// once the queue fills. A completed code point is first written into the queue, and its
// first target unit is then registered into the output register. Registers sit at
// byte address 0 (source format) and 4 (target format); change them only while no
// text is in flight. Writing the source format drops any half-gathered sequence.
// depends on utfx_pkg, utfx_if, utfx_front, utfx_queue and utfx_back
module unicode_utf_transcoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [utfx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    utfx_in_if.sink                      i_in,
    utfx_out_if.source                   o_out
);

    logic [1:0]       r_source;
    logic [1:0]       r_target;
    logic             w_cfg_wr;
    logic             w_clear;
    logic             w_accept;
    logic             w_pop;
    utfx_pkg::t_push  w_push;
    utfx_pkg::t_point w_head;
    utfx_pkg::t_qstat w_qstat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_clear  = w_cfg_wr && (paddr[2] == utfx_pkg::REG_SOURCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= utfx_pkg::FMT_UTF8;
            r_target <= utfx_pkg::FMT_UTF16;
        end else if (w_cfg_wr) begin
            if (paddr[2] == utfx_pkg::REG_SOURCE) begin
                r_source <= pwdata[1:0];
            end else begin
                r_target <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == utfx_pkg::REG_TARGET) ? {30'b0, r_target}
                                                       : {30'b0, r_source};

    assign i_in.ready = !w_qstat.full;
    assign w_accept   = i_in.valid && i_in.ready;

    utfx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_fmt  (r_source),
        .i_clear       (w_clear),
        .i_accept      (w_accept),
        .i_code_unit   (i_in.code_unit),
        .i_end_of_text (i_in.end_of_text),
        .o_push        (w_push)
    );

    utfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    utfx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target_fmt (r_target),
        .i_head       (w_head),
        .i_head_valid (!w_qstat.empty),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

`ifndef NO_ASSERTIONS
    // queue never holds more than two code points
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count != 2'd3)
        else $error("code point queue overflow");

    // a queue pop loads the final unit of that code point
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_out.valid && o_out.last_in_run))
        else $error("code point retired without a final unit");

    // a code point is only pushed from an accepted request
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> w_accept)
        else $error("code point pushed without a request");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule

### tb/utfx_transcode_checker.sv
`timescale 1ns / 1ps
// checker for the unicode transcoder: tracks the format registers from the apb port,
// predicts the target units of every accepted source unit and compares them in order
// depends on utfx_pkg and utfx_if
module utfx_transcode_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [utfx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    utfx_in_if                           in_mon,
    utfx_out_if                          out_mon,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    typedef struct packed {
        logic [31:0] unit;
        logic        last;
    } t_target_unit;

    t_target_unit expected_units[$];

    logic [1:0]  src_fmt;
    logic [1:0]  tgt_fmt;
    logic [31:0] gathered;
    logic [1:0]  cont_left;
    logic        high_held;
    int          mismatches;
    int          checked;

    task automatic clear_open_sequence();
        gathered  = '0;
        cont_left = '0;
        high_held = 1'b0;
    endtask

    task automatic queue_encoded(input logic [31:0] cp);
        logic [31:0]  units [4];
        logic [31:0]  off;
        int           n;
        int           k;
        t_target_unit item;
        case (tgt_fmt)
            utfx_pkg::FMT_UTF8: begin
                if (cp <= 32'h7F) begin
                    units[0] = cp;
                    n = 1;
                end else if (cp <= 32'h7FF) begin
                    units[0] = (32'hC0 | (cp >> 6)) & 32'hFF;
                    units[1] = 32'h80 | (cp & 32'h3F);
                    n = 2;
                end else if (cp <= 32'hFFFF) begin
                    units[0] = (32'hE0 | (cp >> 12)) & 32'hFF;
                    units[1] = 32'h80 | ((cp >> 6) & 32'h3F);
                    units[2] = 32'h80 | (cp & 32'h3F);
                    n = 3;
                end else begin
                    units[0] = (32'hF0 | (cp >> 18)) & 32'hFF;
                    units[1] = 32'h80 | ((cp >> 12) & 32'h3F);
                    units[2] = 32'h80 | ((cp >> 6) & 32'h3F);
                    units[3] = 32'h80 | (cp & 32'h3F);
                    n = 4;
                end
            end
            utfx_pkg::FMT_UTF16: begin
                if (cp <= 32'hFFFF) begin
                    units[0] = cp;
                    n = 1;
                end else begin
                    off = cp - 32'h10000;
                    units[0] = (32'hD800 | (off >> 10)) & 32'hFFFF;
                    units[1] = 32'hDC00 | (off & 32'h3FF);
                    n = 2;
                end
            end
            default: begin
                units[0] = cp;
                n = 1;
            end
        endcase
        for (k = 0; k < n; k++) begin
            item.unit = units[k];
            item.last = (k == n - 1);
            expected_units.push_back(item);
        end
    endtask

    // decode one source unit; a completed code point is encoded into the queue
    task automatic transcode_unit(input logic [31:0] unit, input logic eot);
        logic [31:0] b;
        logic [31:0] half;
        logic [31:0] cp;
        logic        done;
        int          sh;
        done = 1'b0;
        cp   = '0;
        case (src_fmt)
            utfx_pkg::FMT_UTF8: begin
                b = unit & 32'hFF;
                if (cont_left != 2'd0) begin
                    sh = 6 * (int'(cont_left) - 1);
                    gathered = (gathered | ((b & 32'h3F) << sh)) & 32'h1FFFFF;
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        cp = gathered;
                        gathered = '0;
                        done = 1'b1;
                    end
                end else if (b[7] == 1'b0) begin
                    cp = b;
                    done = 1'b1;
                end else if ((b & 32'hE0) == 32'hC0) begin
                    gathered = (b & 32'h1F) << 6;
                    cont_left = 2'd1;
                end else if ((b & 32'hF0) == 32'hE0) begin
                    gathered = (b & 32'h0F) << 12;
                    cont_left = 2'd2;
                end else if ((b & 32'hF8) == 32'hF0) begin
                    gathered = (b & 32'h07) << 18;
                    cont_left = 2'd3;
                end else begin
                    // bad lead byte decodes to zero
                    cp = '0;
                    done = 1'b1;
                end
            end
            utfx_pkg::FMT_UTF16: begin
                half = unit & 32'hFFFF;
                if (high_held) begin
                    // pairs with whatever follows, wrapping at 32 bits
                    cp = (gathered << 10) + (half - 32'hDC00) + 32'h10000;
                    high_held = 1'b0;
                    gathered = '0;
                    done = 1'b1;
                end else if (half >= 32'hD800 && half <= 32'hDBFF) begin
                    gathered = half - 32'hD800;
                    high_held = 1'b1;
                end else begin
                    cp = half;
                    done = 1'b1;
                end
            end
            default: begin
                cp = unit;
                done = 1'b1;
            end
        endcase
        if (done) queue_encoded(cp);
        if (eot) clear_open_sequence();
    endtask

    task automatic check_result(input logic [31:0] unit, input logic last);
        t_target_unit want;
        checked++;
        if (expected_units.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: unit %h last %b", unit, last);
        end else begin
            want = expected_units.pop_front();
            if (want.unit !== unit || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected unit %h last %b, got unit %h last %b",
                             want.unit, want.last, unit, last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_fmt = utfx_pkg::FMT_UTF8;
            tgt_fmt = utfx_pkg::FMT_UTF16;
            clear_open_sequence();
            expected_units.delete();
            mismatches = 0;
            checked = 0;
        end else begin
            if (out_mon.valid && out_mon.ready)
                check_result(out_mon.out_unit, out_mon.last_in_run);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == utfx_pkg::REG_SOURCE) begin
                    src_fmt = pwdata[1:0];
                    clear_open_sequence();
                end else begin
                    tgt_fmt = pwdata[1:0];
                end
            end
            if (in_mon.valid && in_mon.ready)
                transcode_unit(in_mon.code_unit, in_mon.end_of_text);
        end
        o_pending    = expected_units.size();
        o_fail_count = mismatches;
        o_checked    = checked;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// top of the transcoder testbench: clock, reset, apb format writes, source unit
// stimulus with random gaps and output stalls, and the verdict
// depends on utfx_pkg, utfx_if, unicode_utf_transcoder and utfx_transcode_checker
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int UNITS_PER_PHASE = 20;
    // spare format code, handled as utf-32
    localparam logic [1:0] FMT_SPARE = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [utfx_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    int                             fail_count;
    int                             pending;
    int                             checked;
    int                             cycles = 0;
    int                             units_sent;
    int                             settings_used;
    int                             stall_left;
    logic                           steady;
    logic [31:0]                    burst[$];

    utfx_in_if  in_bus ();
    utfx_out_if out_bus ();

    unicode_utf_transcoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    utfx_transcode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_mon       (in_bus),
        .out_mon      (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output stalls
    initial begin
        stall_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 99) < 25) begin
                out_bus.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    task automatic write_format(input logic reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_unit(input logic [31:0] unit, input logic eot);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.code_unit   <= unit;
        in_bus.end_of_text <= eot;
        do @(posedge i_clk); while (!in_bus.ready);
        units_sent++;
    endtask

    // stop sending and hold off until every expected unit is out
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_formats(input logic [1:0] src, input logic [1:0] tgt,
                               input logic noisy);
        logic [29:0] upper;
        upper = noisy ? 30'($urandom) : 30'd0;
        drain();
        write_format(utfx_pkg::REG_TARGET, {upper, tgt});
        write_format(utfx_pkg::REG_SOURCE, {upper, src});
        settings_used++;
    endtask

    // well-formed sequences with random content, plus some broken ones
    task automatic build_burst(input logic [1:0] fmt);
        int          r;
        int          k;
        int          cnt;
        logic [31:0] cp;
        burst.delete();
        r = $urandom_range(0, 99);
        case (fmt)
            utfx_pkg::FMT_UTF8: begin
                if (r < 30) begin
                    burst.push_back($urandom_range(0, 32'h7F));
                end else if (r < 50) begin
                    cp = $urandom_range(32'h80, 32'h7FF);
                    burst.push_back(32'hC0 | (cp >> 6));
                    burst.push_back(32'h80 | (cp & 32'h3F));
                end else if (r < 68) begin
                    cp = $urandom_range(32'h800, 32'hFFFF);
                    burst.push_back(32'hE0 | (cp >> 12));
                    burst.push_back(32'h80 | ((cp >> 6) & 32'h3F));
                    burst.push_back(32'h80 | (cp & 32'h3F));
                end else if (r < 85) begin
                    cp = $urandom_range(32'h10000, 32'h1FFFFF);
                    burst.push_back(32'hF0 | (cp >> 18));
                    burst.push_back(32'h80 | ((cp >> 12) & 32'h3F));
                    burst.push_back(32'h80 | ((cp >> 6) & 32'h3F));
                    burst.push_back(32'h80 | (cp & 32'h3F));
                end else begin
                    cnt = $urandom_range(1, 3);
                    for (k = 0; k < cnt; k++)
                        burst.push_back($urandom_range(0, 255));
                end
                // the upper bits are ignored, fill them with noise
                foreach (burst[m]) burst[m] = burst[m] | ($urandom & 32'hFFFFFF00);
            end
            utfx_pkg::FMT_UTF16: begin
                if (r < 35) begin
                    burst.push_back($urandom_range(32'hD800, 32'hDBFF));
                    burst.push_back($urandom_range(32'hDC00, 32'hDFFF));
                end else if (r < 75) begin
                    burst.push_back($urandom_range(0, 32'hFFFF));
                end else if (r < 87) begin
                    burst.push_back($urandom_range(32'hDC00, 32'hDFFF));
                end else begin
                    burst.push_back($urandom_range(32'hD800, 32'hDBFF));
                    burst.push_back($urandom_range(0, 32'hFFFF));
                end
                foreach (burst[m]) burst[m] = burst[m] | ($urandom & 32'hFFFF0000);
            end
            default: begin
                if (r < 50) burst.push_back($urandom);
                else burst.push_back($urandom_range(0, 32'h10FFFF));
            end
        endcase
    endtask

    task automatic run_random_phase(input logic [1:0] src, input logic [1:0] tgt);
        int sent;
        set_formats(src, tgt, 1'b1);
        sent = 0;
        while (sent < UNITS_PER_PHASE) begin
            build_burst(src);
            foreach (burst[m]) begin
                send_unit(burst[m], $urandom_range(0, 15) == 0);
                sent++;
            end
            if ($urandom_range(0, 99) < 4) drain();
        end
    endtask

    logic [1:0] src_plan [RANDOM_PHASES] = '{utfx_pkg::FMT_UTF8, utfx_pkg::FMT_UTF8,
        utfx_pkg::FMT_UTF16, utfx_pkg::FMT_UTF16, utfx_pkg::FMT_UTF32,
        utfx_pkg::FMT_UTF32, FMT_SPARE, utfx_pkg::FMT_UTF8, utfx_pkg::FMT_UTF16,
        utfx_pkg::FMT_UTF32};
    logic [1:0] tgt_plan [RANDOM_PHASES] = '{utfx_pkg::FMT_UTF8, utfx_pkg::FMT_UTF32,
        utfx_pkg::FMT_UTF16, utfx_pkg::FMT_UTF8, utfx_pkg::FMT_UTF8,
        utfx_pkg::FMT_UTF16, FMT_SPARE, utfx_pkg::FMT_UTF16, utfx_pkg::FMT_UTF32,
        utfx_pkg::FMT_UTF32};

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.code_unit = '0;
        in_bus.end_of_text = 1'b0;
        units_sent = 0;
        settings_used = 1;
        steady = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset formats: utf-8 in, utf-16 out
        send_unit(32'h00, 1'b0);
        send_unit(32'hFFFFFF7F, 1'b0);
        send_unit(32'hC3, 1'b0);
        send_unit(32'hA9, 1'b0);
        send_unit(32'hE2, 1'b0);
        send_unit(32'h82, 1'b0);
        send_unit(32'hAC, 1'b0);
        send_unit(32'hF0, 1'b0);
        send_unit(32'h9F, 1'b0);
        send_unit(32'h98, 1'b0);
        send_unit(32'h80, 1'b0);
        send_unit(32'hFF, 1'b0);
        // sequence left open at end of text is dropped
        send_unit(32'hE2, 1'b1);
        send_unit(32'h41, 1'b0);

        set_formats(utfx_pkg::FMT_UTF16, utfx_pkg::FMT_UTF8, 1'b0);
        send_unit(32'hD83D, 1'b0);
        send_unit(32'hDE00, 1'b0);
        send_unit(32'hDC00, 1'b0);
        send_unit(32'hD800, 1'b0);
        send_unit(32'h0041, 1'b0);
        send_unit(32'hDBFF, 1'b0);
        send_unit(32'hFFFFFFFF, 1'b0);

        set_formats(utfx_pkg::FMT_UTF32, FMT_SPARE, 1'b0);
        send_unit(32'hFFFFFFFF, 1'b0);
        set_formats(FMT_SPARE, utfx_pkg::FMT_UTF8, 1'b0);
        send_unit(32'hFFFFFFFF, 1'b1);
        send_unit(32'h0010FFFF, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p % 4 == 2);
            run_random_phase(src_plan[p], tgt_plan[p]);
        end
        steady = 1'b0;

        drain();
        repeat (10) @(negedge i_clk);
        $display("sent %0d source units over %0d format settings, all four codes per register",
                 units_sent, settings_used);
        $display("checked %0d target units, %0d failures, %0d still expected",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
